// File: src/assert_macros.svh
// assertion macros shared by the rtl modules
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: src/pms_pkg.sv
// shared types, codes and saturation helpers for the particle motion step unit
// no dependencies
package pms_pkg;

	localparam int AXES = 3;

	typedef logic signed [31:0] word_t;
	typedef logic [1:0] action_t;
	typedef logic [1:0] cfg_index_t;

	localparam action_t ACT_TICK    = 2'd0;
	localparam action_t ACT_SET_POS = 2'd1;
	localparam action_t ACT_SET_SPD = 2'd2;
	localparam action_t ACT_ADD_SPD = 2'd3;

	localparam cfg_index_t CFG_GRAV_X = 2'd0;
	localparam cfg_index_t CFG_GRAV_Y = 2'd1;
	localparam cfg_index_t CFG_GRAV_Z = 2'd2;

	localparam word_t GRAV_X_RESET = 32'sd0;
	localparam word_t GRAV_Y_RESET = 32'sd0;
	localparam word_t GRAV_Z_RESET = -32'sd642253;

	// 0.15 in q16.16
	localparam logic signed [32:0] FLOOR_MARGIN = 33'sd9830;

	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
	} lane_ctl_t;

	typedef struct packed {
		word_t pos;
		word_t spd_t;
		word_t spd_p;
		logic  sat;
	} lane_res_t;

	function automatic logic sat_hit(input logic signed [35:0] x);
		return !((x[35:31] == 5'b00000) || (x[35:31] == 5'b11111));
	endfunction

	function automatic word_t sat_word(input logic signed [35:0] x);
		word_t r;
		if (sat_hit(x)) begin
			r = x[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// File: src/pms_lane.sv
// one axis of the integrator: three registered stages of multiply and add
// depends on pms_pkg
module pms_lane (
	input  logic               clk,
	input  pms_pkg::lane_ctl_t ctl,
	input  pms_pkg::action_t   action,
	input  pms_pkg::word_t     value,
	input  logic [15:0]        delta_time,
	input  pms_pkg::word_t     grav,
	input  pms_pkg::word_t     pos,
	input  pms_pkg::word_t     spd_t,
	input  pms_pkg::word_t     spd_p,
	output pms_pkg::lane_res_t res
);
	import pms_pkg::*;

	// stage 1: speed * dt, g * dt, dt * dt
	logic signed [32:0] spd_sum;
	logic signed [16:0] dt_sx;
	action_t            act_s1;
	word_t              val_s1, grav_s1, pos_s1, st_s1, sp_s1;
	logic signed [49:0] svdt_s1;
	logic signed [48:0] gdt_s1;
	logic [31:0]        dt2_s1;

	assign spd_sum = $signed({spd_t[31], spd_t}) + $signed({spd_p[31], spd_p});
	assign dt_sx   = $signed({1'b0, delta_time});

	always_ff @(posedge clk) begin
		if (ctl.ld1) begin
			act_s1  <= action;
			val_s1  <= value;
			grav_s1 <= grav;
			pos_s1  <= pos;
			st_s1   <= spd_t;
			sp_s1   <= spd_p;
			svdt_s1 <= spd_sum * dt_sx;
			gdt_s1  <= grav * dt_sx;
			dt2_s1  <= delta_time * delta_time;
		end
	end

	// stage 2: g * dt^2, persistent speed sum
	logic signed [48:0] gdt_rnd;
	logic signed [32:0] dv;
	logic signed [33:0] addend;
	logic signed [33:0] psum;
	action_t            act_s2;
	word_t              val_s2, pos_s2, st_s2, sp_s2;
	logic signed [49:0] svdt_s2;
	logic signed [64:0] gdt2_s2;
	logic signed [33:0] psum_s2;

	assign gdt_rnd = gdt_s1 + 49'sd32768;
	assign dv      = gdt_rnd[48:16];
	assign addend  = (act_s1 == ACT_ADD_SPD) ? $signed({{2{val_s1[31]}}, val_s1})
	                                         : $signed({dv[32], dv});
	assign psum    = $signed({{2{sp_s1[31]}}, sp_s1}) + addend;

	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			act_s2  <= act_s1;
			val_s2  <= val_s1;
			pos_s2  <= pos_s1;
			st_s2   <= st_s1;
			sp_s2   <= sp_s1;
			svdt_s2 <= svdt_s1;
			gdt2_s2 <= grav_s1 * $signed({1'b0, dt2_s1});
			psum_s2 <= psum;
		end
	end

	// stage 3: sum in q16.32, round half up, saturate
	logic signed [47:0] gterm;
	logic signed [51:0] acc;
	logic signed [35:0] rnd;
	logic signed [35:0] psum_x;
	logic               is_tick, is_add;

	assign gterm   = gdt2_s2[64:17];
	assign acc     = $signed({{4{pos_s2[31]}}, pos_s2, 16'h0000})
	               + $signed({{2{svdt_s2[49]}}, svdt_s2})
	               + $signed({{4{gterm[47]}}, gterm})
	               + 52'sd32768;
	assign rnd     = acc[51:16];
	assign psum_x  = $signed({{2{psum_s2[33]}}, psum_s2});
	assign is_tick = (act_s2 == ACT_TICK);
	assign is_add  = (act_s2 == ACT_ADD_SPD);

	always_ff @(posedge clk) begin
		if (ctl.ld3) begin
			res.pos   <= is_tick ? sat_word(rnd)
			           : (act_s2 == ACT_SET_POS) ? val_s2 : pos_s2;
			res.spd_t <= (act_s2 == ACT_SET_SPD) ? val_s2 : st_s2;
			res.spd_p <= (is_tick || is_add) ? sat_word(psum_x) : sp_s2;
			res.sat   <= (is_tick && (sat_hit(rnd) || sat_hit(psum_x)))
			           || (is_add && sat_hit(psum_x));
		end
	end

endmodule

// File: src/pms_merge.sv
// merge stage: floor handling, state registers and the output word
// depends on pms_pkg and assert_macros.svh
module pms_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               done,
	input  pms_pkg::action_t   action,
	input  pms_pkg::word_t     floor_height,
	input  pms_pkg::lane_res_t res [pms_pkg::AXES],
	output pms_pkg::word_t     pos [pms_pkg::AXES],
	output pms_pkg::word_t     spd_t [pms_pkg::AXES],
	output pms_pkg::word_t     spd_p [pms_pkg::AXES],
	output logic               take,
	output logic               out_valid,
	input  logic               out_stall,
	output pms_pkg::word_t     pos_x,
	output pms_pkg::word_t     pos_y,
	output pms_pkg::word_t     pos_z,
	output logic               on_floor,
	output logic               saturated
);
	import pms_pkg::*;

	word_t              pos_q [AXES];
	word_t              st_q [AXES];
	word_t              sp_q [AXES];
	logic               floor_q, sat_q, out_valid_q;
	logic               below;
	logic               near;
	logic signed [32:0] fl_lim;
	logic               any_sat;

	assign take    = done && (!out_valid_q || !out_stall);
	assign below   = (action == ACT_TICK) && (pos_q[2] < floor_height);
	assign fl_lim  = $signed({floor_height[31], floor_height}) + FLOOR_MARGIN;
	assign near    = $signed({res[2].pos[31], res[2].pos}) < fl_lim;
	assign any_sat = res[0].sat || res[1].sat || res[2].sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				pos_q[i] <= '0;
				st_q[i]  <= '0;
				sp_q[i]  <= '0;
			end
			floor_q     <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (below) begin
					pos_q[2] <= floor_height;
					for (int i = 0; i < AXES; i++) begin
						sp_q[i] <= '0;
					end
					floor_q <= 1'b1;
					sat_q   <= 1'b0;
				end else begin
					for (int i = 0; i < AXES; i++) begin
						pos_q[i] <= res[i].pos;
						st_q[i]  <= res[i].spd_t;
						sp_q[i]  <= res[i].spd_p;
					end
					if (action == ACT_TICK) begin
						floor_q <= near;
					end
					sat_q <= any_sat;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			pos[i]   = pos_q[i];
			spd_t[i] = st_q[i];
			spd_p[i] = sp_q[i];
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_q[0];
	assign pos_y     = pos_q[1];
	assign pos_z     = pos_q[2];
	assign on_floor  = floor_q;
	assign saturated = sat_q;

	`include "assert_macros.svh"

	`ASSERT_CLK(a_setpos_nosat, take && (action == ACT_SET_POS) |=> !sat_q, "set position saturated")
	`ASSERT_CLK(a_floor_snap, take && below |=> floor_q && (pos_q[2] == $past(floor_height)), "floor snap lost")
	`ASSERT_CLK(a_setspd_keep, take && (action == ACT_SET_SPD) |=> pos_q[0] == $past(pos_q[0]), "set speed moved x")

endmodule

// File: src/particle_motion_step_unit.sv
// top level of the particle motion step unit: handshake, gravity registers,
// three axis lanes and the merge stage; depends on pms_pkg, pms_lane, pms_merge
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    action, value_x/y/z, delta_time, floor_height
//  output    out        out_valid / out_stall  pos_x/y/z, on_floor, saturated
//  config    in         cfg_wr_en              cfg_index, cfg_data (gravity x, y, z)
//
// a result word is presented after its input word passes three lane stages (speed * dt,
// g * dt and dt * dt, then g * dt^2 and the persistent speed sum, then the q16.32 sum)
// and the merge stage commits it to the output register
// one word is in flight at a time; the next is accepted the cycle after the
// merge stage commits, even while the result word is still stalled
// a stalled result holds the last lane stage until the output register frees
// reset clears the particle state, the floor flag and loads default gravity
module particle_motion_step_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pms_pkg::action_t     action,
	input  pms_pkg::word_t       value_x,
	input  pms_pkg::word_t       value_y,
	input  pms_pkg::word_t       value_z,
	input  logic [15:0]          delta_time,
	input  pms_pkg::word_t       floor_height,
	output logic                 out_valid,
	input  logic                 out_stall,
	output pms_pkg::word_t       pos_x,
	output pms_pkg::word_t       pos_y,
	output pms_pkg::word_t       pos_z,
	output logic                 on_floor,
	output logic                 saturated,
	input  logic                 cfg_wr_en,
	input  pms_pkg::cfg_index_t  cfg_index,
	input  pms_pkg::word_t       cfg_data
);
	import pms_pkg::*;

	// gravity registers; the user must write them only while idle, the block does not enforce it
	word_t grav_q [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q[0] <= GRAV_X_RESET;
			grav_q[1] <= GRAV_Y_RESET;
			grav_q[2] <= GRAV_Z_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_GRAV_X: grav_q[0] <= cfg_data;
				CFG_GRAV_Y: grav_q[1] <= cfg_data;
				CFG_GRAV_Z: grav_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valids: one word travels through the lanes at a time
	logic      v1_q, v2_q, v3_q;
	logic      accept;
	logic      take;
	action_t   act_q;
	word_t     fl_q;
	lane_ctl_t ctl;

	assign in_stall = v1_q || v2_q || v3_q;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			v1_q <= accept;
			v2_q <= v1_q;
			v3_q <= v2_q || (v3_q && !take);
		end
	end

	// action and floor height are needed again at the merge stage
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			fl_q  <= floor_height;
		end
	end

	assign ctl.ld1 = accept;
	assign ctl.ld2 = v1_q;
	assign ctl.ld3 = v2_q;

	// one lane per axis
	word_t     val_in [AXES];
	word_t     pos_st [AXES];
	word_t     spd_t_st [AXES];
	word_t     spd_p_st [AXES];
	lane_res_t lane_res [AXES];

	assign val_in[0] = value_x;
	assign val_in[1] = value_y;
	assign val_in[2] = value_z;

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		pms_lane u_lane (
			.clk        (clk),
			.ctl        (ctl),
			.action     (action),
			.value      (val_in[a]),
			.delta_time (delta_time),
			.grav       (grav_q[a]),
			.pos        (pos_st[a]),
			.spd_t      (spd_t_st[a]),
			.spd_p      (spd_p_st[a]),
			.res        (lane_res[a])
		);
	end

	// merge: floor snap, state commit, result word
	pms_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.done         (v3_q),
		.action       (act_q),
		.floor_height (fl_q),
		.res          (lane_res),
		.pos          (pos_st),
		.spd_t        (spd_t_st),
		.spd_p        (spd_p_st),
		.take         (take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.on_floor     (on_floor),
		.saturated    (saturated)
	);

	`include "assert_macros.svh"

	`ASSERT_NEVER(a_one_in_flight, !$onehot0({v1_q, v2_q, v3_q}), "more than one word in flight")
	`ASSERT_CLK(a_accept_starts, accept |=> v1_q && !v2_q && !v3_q, "accepted word not in stage one")
	`ASSERT_CLK(a_take_shows, take |=> out_valid, "committed word not presented")

endmodule

// File: bench/tb.sv
// self-checking bench for particle_motion_step_unit: directed table, then random phases
// across gravity settings, checked against typed results or a cycle-free q16.16 predictor
// depends on pms_pkg and the particle_motion_step_unit rtl
`timescale 1ns / 1ps

module tb;
	import pms_pkg::*;

	// spare register index, the block ignores writes to it
	localparam cfg_index_t CFG_SPARE = 2'd3;

	localparam word_t  Q_MAX       = 32'sh7FFF_FFFF;
	localparam word_t  Q_MIN       = 32'sh8000_0000;
	// 0.15 in q16.16, compared at full width
	localparam longint NEAR_FLOOR  = 64'sd9830;
	localparam int     PHASES      = 6;
	localparam int     PHASE_WORDS = 210;
	localparam int     CYCLE_LIMIT = 400000;

	// one input word and one result word as the bench sees them
	typedef struct packed {
		action_t     act;
		word_t       vx;
		word_t       vy;
		word_t       vz;
		logic [15:0] dt;
		word_t       fl;
	} motion_word_t;

	typedef struct packed {
		word_t px;
		word_t py;
		word_t pz;
		logic  flr;
		logic  sat;
	} pose_t;

	// directed row: result typed in when known holds, otherwise predicted
	typedef struct packed {
		motion_word_t w;
		logic         known;
		pose_t        want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	action_t     action;
	word_t       value_x;
	word_t       value_y;
	word_t       value_z;
	logic [15:0] delta_time;
	word_t       floor_height;
	logic        out_valid;
	logic        out_stall;
	word_t       pos_x;
	word_t       pos_y;
	word_t       pos_z;
	logic        on_floor;
	logic        saturated;
	logic        cfg_wr_en;
	cfg_index_t  cfg_index;
	word_t       cfg_data;

	particle_motion_step_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.value_x      (value_x),
		.value_y      (value_y),
		.value_z      (value_z),
		.delta_time   (delta_time),
		.floor_height (floor_height),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.on_floor     (on_floor),
		.saturated    (saturated),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// predictor copy of the particle and the gravity registers
	word_t grav[3];
	word_t pos_st[3];
	word_t spd_tr[3];
	word_t spd_pe[3];
	logic  flr_st;
	bit    step_sat;

	// predicted poses in acceptance order, oldest at the front
	pose_t     expected_poses[$];
	stim_row_t directed_rows[$];

	int sent_words   = 0;
	int tick_words   = 0;
	int snap_count   = 0;
	int sat_steps    = 0;
	int results_seen = 0;
	int mismatches   = 0;
	int cycle_count  = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycle_count,
				expected_poses.size());
			$display("particle_motion_step_unit regression: fail");
			$finish;
		end
	end

	// clamp to 32 bits, remembering that this step hit a rail
	function automatic word_t clamp32(input longint x);
		if (x > longint'(Q_MAX)) begin
			step_sat = 1'b1;
			return Q_MAX;
		end
		if (x < longint'(Q_MIN)) begin
			step_sat = 1'b1;
			return Q_MIN;
		end
		return word_t'(x);
	endfunction

	// q16.32 to q16.16, round half up
	function automatic longint round_half_up(input longint x);
		return (x + 64'sd32768) >>> 16;
	endfunction

	// apply one accepted word to the predicted particle and return the result word
	task automatic advance_particle(input motion_word_t w, output pose_t p);
		longint d;
		longint fl;
		longint acc;
		longint dv;
		word_t  v[3];
		word_t  np[3];
		int     i;
		step_sat = 1'b0;
		v[0] = w.vx;
		v[1] = w.vy;
		v[2] = w.vz;
		case (w.act)
			ACT_TICK: begin
				tick_words++;
				d = longint'(w.dt);
				fl = longint'(w.fl);
				if (longint'(pos_st[2]) < fl) begin
					// old z under the floor: snap z only, drop persistent speed
					pos_st[2] = w.fl;
					for (i = 0; i < 3; i++) spd_pe[i] = '0;
					flr_st = 1'b1;
					snap_count++;
				end else begin
					for (i = 0; i < 3; i++) begin
						acc = longint'(pos_st[i]) * 64'sd65536;
						acc += (longint'(spd_tr[i]) + longint'(spd_pe[i])) * d;
						acc += (longint'(grav[i]) * d * d) >>> 17;
						np[i] = clamp32(round_half_up(acc));
					end
					for (i = 0; i < 3; i++) begin
						dv = round_half_up(longint'(grav[i]) * d);
						pos_st[i] = np[i];
						spd_pe[i] = clamp32(longint'(spd_pe[i]) + dv);
					end
					flr_st = longint'(pos_st[2]) < fl + NEAR_FLOOR;
				end
			end
			ACT_SET_POS: begin
				for (i = 0; i < 3; i++) pos_st[i] = v[i];
			end
			ACT_SET_SPD: begin
				for (i = 0; i < 3; i++) spd_tr[i] = v[i];
			end
			default: begin
				for (i = 0; i < 3; i++) spd_pe[i] = clamp32(longint'(spd_pe[i]) + longint'(v[i]));
			end
		endcase
		if (step_sat) sat_steps++;
		p.px = pos_st[0];
		p.py = pos_st[1];
		p.pz = pos_st[2];
		p.flr = flr_st;
		p.sat = step_sat;
	endtask

	// offer one word, hold it until accepted, then predict its result
	// the gap runs in stretches of zero so that back-to-back words also occur
	task automatic send_motion(input motion_word_t w, output pose_t p);
		int gap;
		gap = (sent_words % 100 < 30) ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		action       <= w.act;
		value_x      <= w.vx;
		value_y      <= w.vy;
		value_z      <= w.vz;
		delta_time   <= w.dt;
		floor_height <= w.fl;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		sent_words++;
		advance_particle(w, p);
	endtask

	// stop offering and wait for every predicted word, plus the pipe depth
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_gravity(input cfg_index_t idx, input word_t data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_GRAV_X: grav[0] = data;
			CFG_GRAV_Y: grav[1] = data;
			CFG_GRAV_Z: grav[2] = data;
			default: ;
		endcase
	endtask

	task automatic plain_row(input action_t act, input word_t vx, input word_t vy,
		input word_t vz, input logic [15:0] dt, input word_t fl);
		stim_row_t r;
		r.w.act = act;
		r.w.vx = vx;
		r.w.vy = vy;
		r.w.vz = vz;
		r.w.dt = dt;
		r.w.fl = fl;
		r.known = 1'b0;
		r.want = '0;
		directed_rows.push_back(r);
	endtask

	task automatic known_row(input action_t act, input word_t vx, input word_t vy,
		input word_t vz, input logic [15:0] dt, input word_t fl,
		input word_t px, input word_t py, input word_t pz, input logic flr, input logic sat);
		stim_row_t r;
		plain_row(act, vx, vy, vz, dt, fl);
		r = directed_rows.pop_back();
		r.known = 1'b1;
		r.want.px = px;
		r.want.py = py;
		r.want.pz = pz;
		r.want.flr = flr;
		r.want.sat = sat;
		directed_rows.push_back(r);
	endtask

	// mostly values of moderate size, with full-range words and rails mixed in
	function automatic word_t rand_q();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel <= 5) return int'($urandom_range(0, 26214400)) - 13107200;
		if (sel <= 7) return $urandom;
		if (sel == 8) begin
			case ($urandom_range(0, 3))
				0: return Q_MAX;
				1: return Q_MIN;
				2: return '0;
				default: return -32'sd1;
			endcase
		end
		return int'($urandom_range(0, 131072)) - 65536;
	endfunction

	// random word shaped around the predicted particle: floors near z hit the
	// snap and the margin, floors well under z let it fall freely
	function automatic motion_word_t random_motion();
		motion_word_t w;
		int unsigned  sel;
		sel = $urandom_range(0, 9);
		if (sel <= 4) w.act = ACT_TICK;
		else if (sel == 5) w.act = ACT_SET_POS;
		else if (sel == 6) w.act = ACT_SET_SPD;
		else w.act = ACT_ADD_SPD;
		w.vx = rand_q();
		w.vy = rand_q();
		w.vz = rand_q();
		sel = $urandom_range(0, 9);
		if (sel <= 6) w.dt = 16'($urandom_range(0, 4096));
		else if (sel <= 8) w.dt = 16'($urandom_range(0, 65535));
		else w.dt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		sel = $urandom_range(0, 9);
		if (sel <= 5) w.fl = int'(pos_st[2]) + int'($urandom_range(0, 58980)) - 29490;
		else if (sel <= 7) w.fl = int'(pos_st[2]) - int'($urandom_range(0, 1310720));
		else if (sel == 8) w.fl = $urandom;
		else w.fl = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
		return w;
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// receiver: random stall per word, stretches with none, and one long
	// hold-off so the block fills and pushes back on the sender
	initial begin : result_side
		int    hold;
		pose_t want;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (results_seen == 400) hold = 300;
			else if (results_seen % 120 < 40) hold = 0;
			else hold = $urandom_range(0, 17);
			if (hold > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				@(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			results_seen++;
			if (expected_poses.size() == 0) begin
				$error("result word with no prediction pending");
				mismatches++;
			end else begin
				want = expected_poses.pop_front();
				check_field("pos_x", want.px, pos_x);
				check_field("pos_y", want.py, pos_y);
				check_field("pos_z", want.pz, pos_z);
				check_field("on_floor", want.flr, on_floor);
				check_field("saturated", want.sat, saturated);
			end
		end
	end

	// sender: directed table, then random phases under changing gravity
	initial begin : stimulus_side
		pose_t        p;
		motion_word_t w;
		word_t        gx;
		word_t        gy;
		word_t        gz;
		int           k;
		int           ph;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_TICK;
		value_x      = '0;
		value_y      = '0;
		value_z      = '0;
		delta_time   = '0;
		floor_height = '0;
		cfg_wr_en    = 1'b0;
		cfg_index    = CFG_GRAV_X;
		cfg_data     = '0;
		grav[0] = GRAV_X_RESET;
		grav[1] = GRAV_Y_RESET;
		grav[2] = GRAV_Z_RESET;
		for (k = 0; k < 3; k++) begin
			pos_st[k] = '0;
			spd_tr[k] = '0;
			spd_pe[k] = '0;
		end
		flr_st = 1'b0;

		// directed table, reset gravity throughout
		// zero step from rest lands inside the floor margin
		known_row(ACT_TICK, 0, 0, 0, 16'd0, 0, 0, 0, 0, 1'b1, 1'b0);
		known_row(ACT_SET_POS, Q_MAX, Q_MIN, 32'sd6553600, 16'd0, 0,
			Q_MAX, Q_MIN, 32'sd6553600, 1'b1, 1'b0);
		known_row(ACT_TICK, 0, 0, 0, 16'd0, Q_MIN, Q_MAX, Q_MIN, 32'sd6553600, 1'b0, 1'b0);
		known_row(ACT_SET_SPD, Q_MAX, Q_MIN, 0, 16'd0, 0,
			Q_MAX, Q_MIN, 32'sd6553600, 1'b0, 1'b0);
		known_row(ACT_ADD_SPD, Q_MAX, Q_MIN, 0, 16'd0, 0,
			Q_MAX, Q_MIN, 32'sd6553600, 1'b0, 1'b0);
		// persistent speed already on the rails, so this add clamps
		known_row(ACT_ADD_SPD, 32'sd1, -32'sd1, 0, 16'd0, 0,
			Q_MAX, Q_MIN, 32'sd6553600, 1'b0, 1'b1);
		plain_row(ACT_TICK, 0, 0, 0, 16'hFFFF, Q_MIN);
		// floor far above: z snaps
		plain_row(ACT_TICK, 0, 0, 0, 16'd1, Q_MAX);
		known_row(ACT_SET_POS, 0, 0, 0, 16'd0, 0, 0, 0, 0, 1'b1, 1'b0);
		known_row(ACT_SET_SPD, 0, 0, 0, 16'd0, 0, 0, 0, 0, 1'b1, 1'b0);
		plain_row(ACT_TICK, 0, 0, 0, 16'd32768, -32'sd65536);
		plain_row(ACT_TICK, 0, 0, 0, 16'd16384, -32'sd131072);
		plain_row(ACT_SET_SPD, 32'sd65536, -32'sd65536, 32'sd196608, 16'd0, 0);
		plain_row(ACT_TICK, 0, 0, 0, 16'hFFFF, Q_MIN);
		plain_row(ACT_SET_POS, 0, 0, Q_MAX, 16'd0, 0);
		// floor plus margin must not wrap at the top rail
		known_row(ACT_TICK, 0, 0, 0, 16'd0, Q_MAX, 0, 0, Q_MAX, 1'b1, 1'b0);
		known_row(ACT_TICK, 0, 0, 0, 16'd0, Q_MIN, 0, 0, Q_MAX, 1'b0, 1'b0);
		known_row(ACT_SET_POS, 0, 0, Q_MIN, 16'd0, 0, 0, 0, Q_MIN, 1'b0, 1'b0);
		known_row(ACT_TICK, 0, 0, 0, 16'd100, Q_MIN + 1, 0, 0, Q_MIN + 1, 1'b1, 1'b0);
		known_row(ACT_ADD_SPD, Q_MIN, Q_MIN, Q_MIN, 16'd0, 0, 0, 0, Q_MIN + 1, 1'b1, 1'b0);
		known_row(ACT_ADD_SPD, -32'sd1, 0, 0, 16'd0, 0, 0, 0, Q_MIN + 1, 1'b1, 1'b1);
		plain_row(ACT_TICK, 0, 0, 0, 16'hFFFF, Q_MIN);
		plain_row(ACT_SET_SPD, Q_MIN, Q_MAX, -32'sd1, 16'd0, 0);
		plain_row(ACT_TICK, 0, 0, 0, 16'hFFFF, Q_MIN);

		// single reset at the start
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < directed_rows.size(); k++) begin
			send_motion(directed_rows[k].w, p);
			expected_poses.push_back(directed_rows[k].known ? directed_rows[k].want : p);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			// gravity is only rewritten with nothing in flight
			settle();
			case (ph)
				0: begin gx = GRAV_X_RESET; gy = GRAV_Y_RESET; gz = GRAV_Z_RESET; end
				1: begin gx = '0; gy = '0; gz = '0; end
				2: begin gx = Q_MAX; gy = Q_MIN; gz = Q_MAX; end
				3: begin gx = Q_MIN; gy = Q_MAX; gz = Q_MIN; end
				4: begin
					gx = int'($urandom_range(0, 2621440)) - 1310720;
					gy = int'($urandom_range(0, 2621440)) - 1310720;
					gz = int'($urandom_range(0, 2621440)) - 1310720;
				end
				default: begin gx = $urandom; gy = $urandom; gz = $urandom; end
			endcase
			write_gravity(CFG_GRAV_X, gx);
			write_gravity(CFG_GRAV_Y, gy);
			write_gravity(CFG_GRAV_Z, gz);
			write_gravity(CFG_SPARE, $urandom);
			for (k = 0; k < PHASE_WORDS; k++) begin
				// sender pause mid-run until the block has drained
				if (ph == 2 && k == PHASE_WORDS / 2) settle();
				w = random_motion();
				send_motion(w, p);
				expected_poses.push_back(p);
			end
		end

		settle();
		repeat (20) @(posedge clk);
		$display("%0d words sent, %0d results checked, %0d ticks, %0d floor snaps",
			sent_words, results_seen, tick_words, snap_count);
		$display("%0d saturating steps over %0d gravity settings, %0d mismatches",
			sat_steps, PHASES, mismatches);
		if (mismatches == 0) begin
			$display("particle_motion_step_unit regression: pass");
		end else begin
			$display("particle_motion_step_unit regression: fail");
		end
		$finish;
	end

endmodule
